[src/arm_load_store_writeback_decoder_unit_defines.svh]
// ----------------------------------------------------------------------------
// load/store writeback decoder assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ARM_LOAD_STORE_WRITEBACK_DECODER_UNIT_DEFINES_SVH
`define ARM_LOAD_STORE_WRITEBACK_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define LSWB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define LSWB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LSWB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LSWB_ASSERT(lbl, clk, rst, prop, msg)
`define LSWB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define LSWB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[src/lswb_pkg.sv]
// ----------------------------------------------------------------------------
// lswb_pkg
// shared types and constants of the load/store writeback decoder
// ----------------------------------------------------------------------------
package lswb_pkg;

  localparam int WordW = 32;
  localparam int RegW  = 4;
  localparam int SizeW = 4;

  // shift types
  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // access sizes
  localparam logic [SizeW-1:0] SIZE_BYTE = 4'd1;
  localparam logic [SizeW-1:0] SIZE_HALF = 4'd2;
  localparam logic [SizeW-1:0] SIZE_WORD = 4'd4;
  localparam logic [SizeW-1:0] SIZE_DUAL = 4'd8;

  // arm class match
  localparam logic [WordW-1:0] ARM_CLASS_MASK = 32'h0C00_0000;
  localparam logic [WordW-1:0] ARM_CLASS_WB   = 32'h0400_0000;
  localparam logic [WordW-1:0] ARM_CLASS_EXT  = 32'h0000_0000;

  // arm extra form op field
  localparam logic [3:0] EXT_HALF  = 4'hB;
  localparam logic [3:0] EXT_LDRD  = 4'hD;
  localparam logic [3:0] EXT_STRD  = 4'hF;

  // thumb group match
  localparam logic [WordW-1:0] THUMB_WIDE_MIN = 32'h0000_E800;
  localparam logic [6:0]       T_STORE_MASK   = 7'h71;
  localparam logic [6:0]       T_LOAD_MASK    = 7'h67;
  localparam logic [6:0]       T_LOAD_BYTE    = 7'h01;
  localparam logic [6:0]       T_LOAD_HALF    = 7'h03;
  localparam logic [6:0]       T_LOAD_WORD    = 7'h05;

  localparam logic [RegW-1:0] REG_PC = 4'd15;

  typedef struct packed {
    logic              ok;
    logic              store;
    logic [SizeW-1:0]  bytes;
    logic              sx;
    logic [RegW-1:0]   rt;
    logic              wb_en;
    logic [RegW-1:0]   rn;
    logic [WordW-1:0]  wb_value;
  } result_t;

  localparam result_t RESULT_NONE = '0;

endpackage

[src/lswb_shifter.sv]
// ----------------------------------------------------------------------------
// lswb_shifter
// immediate shifter for arm register offsets: lsl, lsr, asr, ror, rrx
// ----------------------------------------------------------------------------
module lswb_shifter (
  input  logic [lswb_pkg::WordW-1:0] value,
  input  logic [1:0]                 shift_type,
  input  logic [4:0]                 amount,
  input  logic                       carry,
  output logic [lswb_pkg::WordW-1:0] result
);
  import lswb_pkg::*;

  logic [2*WordW-1:0] rot;

  assign rot = {value, value} >> amount;

  always_comb begin
    unique case (shift_type)
      SH_LSL: result = value << amount;
      SH_LSR: result = (amount == 5'd0) ? '0 : (value >> amount);
      SH_ASR: begin
        if (amount == 5'd0) begin
          result = {WordW{value[WordW-1]}};
        end else begin
          result = WordW'($signed(value) >>> amount);
        end
      end
      SH_ROR: begin
        if (amount == 5'd0) begin
          result = {carry, value[WordW-1:1]};
        end else begin
          result = rot[WordW-1:0];
        end
      end
      default: result = value;
    endcase
  end

endmodule

[src/lswb_arm_dec.sv]
// ----------------------------------------------------------------------------
// lswb_arm_dec
// arm load/store decode: word/byte and extra forms, offset and new base
// ----------------------------------------------------------------------------
module lswb_arm_dec (
  input  logic [lswb_pkg::WordW-1:0] instr,
  input  logic                       carry,
  input  logic [lswb_pkg::WordW-1:0] base,
  input  logic [lswb_pkg::WordW-1:0] index,
  output lswb_pkg::result_t          res
);
  import lswb_pkg::*;

  logic [WordW-1:0] shifted;
  logic [WordW-1:0] off;
  logic [RegW-1:0]  rt;
  logic [RegW-1:0]  rn;
  logic             l_bit;
  logic             w_bit;
  logic             u_bit;
  logic             p_bit;
  logic             cls_ok;
  logic             store;
  logic [SizeW-1:0] bytes;
  logic             sx;
  logic [3:0]       op;

  assign rt    = instr[15:12];
  assign rn    = instr[19:16];
  assign l_bit = instr[20];
  assign w_bit = instr[21];
  assign u_bit = instr[23];
  assign p_bit = instr[24];
  assign op    = instr[7:4];

  lswb_shifter u_shift (
    .value      (index),
    .shift_type (instr[6:5]),
    .amount     (instr[11:7]),
    .carry      (carry),
    .result     (shifted)
  );

  always_comb begin
    cls_ok = 1'b0;
    store  = 1'b0;
    bytes  = SIZE_WORD;
    sx     = 1'b0;
    off    = '0;
    if ((instr & ARM_CLASS_MASK) == ARM_CLASS_WB) begin
      cls_ok = 1'b1;
      store  = !l_bit;
      bytes  = instr[22] ? SIZE_BYTE : SIZE_WORD;
      off    = instr[25] ? shifted : {20'd0, instr[11:0]};
    end else if ((instr & ARM_CLASS_MASK) == ARM_CLASS_EXT) begin
      off = instr[22] ? {24'd0, instr[11:8], instr[3:0]} : index;
      unique case (op)
        EXT_HALF: begin
          cls_ok = 1'b1;
          store  = !l_bit;
          bytes  = SIZE_HALF;
        end
        EXT_LDRD: begin
          cls_ok = 1'b1;
          store  = 1'b0;
          bytes  = l_bit ? SIZE_BYTE : SIZE_DUAL;
          sx     = l_bit;
        end
        EXT_STRD: begin
          cls_ok = 1'b1;
          store  = !l_bit;
          bytes  = l_bit ? SIZE_HALF : SIZE_DUAL;
          sx     = l_bit;
        end
        default: cls_ok = 1'b0;
      endcase
    end
  end

  always_comb begin
    res = RESULT_NONE;
    if (cls_ok && rt != REG_PC && rn != REG_PC && !(p_bit && !w_bit)) begin
      res.ok       = 1'b1;
      res.store    = store;
      res.bytes    = bytes;
      res.sx       = sx;
      res.rt       = rt;
      res.wb_en    = 1'b1;
      res.rn       = rn;
      res.wb_value = u_bit ? (base + off) : (base - off);
    end
  end

endmodule

[src/lswb_thumb_dec.sv]
// ----------------------------------------------------------------------------
// lswb_thumb_dec
// thumb wide single store/load decode with immediate writeback
// ----------------------------------------------------------------------------
module lswb_thumb_dec (
  input  logic [lswb_pkg::WordW-1:0] instr,
  input  logic [lswb_pkg::WordW-1:0] fault_base,
  output lswb_pkg::result_t          res
);
  import lswb_pkg::*;

  logic [6:0]       op2;
  logic [6:0]       ld_code;
  logic [2:0]       sz;
  logic [1:0]       sgn;
  logic             grp_ok;
  logic             store;
  logic [SizeW-1:0] bytes;
  logic             sx;
  logic [RegW-1:0]  rn;
  logic [WordW-1:0] imm8;
  logic [WordW-1:0] post;

  assign op2     = instr[26:20];
  assign ld_code = op2 & T_LOAD_MASK;
  assign sz      = instr[23:21];
  assign sgn     = instr[24:23];
  assign rn      = instr[19:16];
  assign imm8    = {24'd0, instr[7:0]};
  assign post    = instr[9] ? (fault_base + imm8) : (fault_base - imm8);

  always_comb begin
    grp_ok = 1'b0;
    store  = 1'b0;
    bytes  = SIZE_WORD;
    sx     = 1'b0;
    if ((op2 & T_STORE_MASK) == 7'd0) begin
      store = 1'b1;
      unique case (sz)
        3'd0:    begin grp_ok = 1'b1; bytes = SIZE_BYTE; end
        3'd1:    begin grp_ok = 1'b1; bytes = SIZE_HALF; end
        3'd2:    begin grp_ok = 1'b1; bytes = SIZE_WORD; end
        default: grp_ok = 1'b0;
      endcase
    end else if (ld_code == T_LOAD_BYTE || ld_code == T_LOAD_HALF
                 || ld_code == T_LOAD_WORD) begin
      bytes = (ld_code == T_LOAD_BYTE) ? SIZE_BYTE :
              (ld_code == T_LOAD_HALF) ? SIZE_HALF : SIZE_WORD;
      if (sgn == 2'd0) begin
        grp_ok = 1'b1;
      end else if (sgn == 2'd2 && ld_code != T_LOAD_WORD) begin
        grp_ok = 1'b1;
        sx     = 1'b1;
      end
    end
  end

  always_comb begin
    res = RESULT_NONE;
    if (instr >= THUMB_WIDE_MIN && instr[28:27] == 2'b11 && grp_ok
        && instr[11] && instr[8] && rn != REG_PC) begin
      res.ok       = 1'b1;
      res.store    = store;
      res.bytes    = bytes;
      res.sx       = sx;
      res.rt       = instr[15:12];
      res.wb_en    = 1'b1;
      res.rn       = rn;
      res.wb_value = instr[10] ? fault_base : post;
    end
  end

endmodule

[src/arm_load_store_writeback_decoder_unit.sv]
// ----------------------------------------------------------------------------
// arm_load_store_writeback_decoder_unit
// decodes a trapped load/store word into access and base writeback info
//
// channel  dir  tdata                                   tuser
// s_axis   in   instr, carry, base, index, fault addr   thumb_mode
// m_axis   out  decode result and new base              -
//
// one word per cycle sustained while m_axis accepts results; a word passes
// through the input register, decode and the result register
// rst clears both valid flags; payload registers are not reset
// a stall on m_axis holds the result and backs up into the input register
// ----------------------------------------------------------------------------
`include "arm_load_store_writeback_decoder_unit_defines.svh"

module arm_load_store_writeback_decoder_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // instruction[31:0], carry_flag[32], base_value[64:33],
  // index_value[96:65], fault_address[128:97], zero pad[135:129]
  input  logic [135:0] s_axis_tdata,
  // thumb_mode[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // decoded_ok[0], is_store[1], access_bytes[5:2], sign_ext[6],
  // target_reg[10:7], writeback_enable[11], writeback_reg[15:12],
  // writeback_value[47:16]
  output logic [47:0]  m_axis_tdata
);
  import lswb_pkg::*;

  logic             in_valid;
  logic [WordW-1:0] in_instr;
  logic             in_thumb;
  logic             in_carry;
  logic [WordW-1:0] in_base;
  logic [WordW-1:0] in_index;
  logic [WordW-1:0] in_fault;
  logic             out_free;
  result_t          arm_res;
  result_t          thumb_res;
  result_t          dec_res;
  result_t          out_res;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_free;

  lswb_arm_dec u_arm (
    .instr (in_instr),
    .carry (in_carry),
    .base  (in_base),
    .index (in_index),
    .res   (arm_res)
  );

  lswb_thumb_dec u_thumb (
    .instr      (in_instr),
    .fault_base (in_fault),
    .res        (thumb_res)
  );

  assign dec_res = in_thumb ? thumb_res : arm_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_instr <= s_axis_tdata[31:0];
      in_carry <= s_axis_tdata[32];
      in_base  <= s_axis_tdata[64:33];
      in_index <= s_axis_tdata[96:65];
      in_fault <= s_axis_tdata[128:97];
      in_thumb <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid) begin
      out_res <= dec_res;
    end
  end

  assign m_axis_tdata = {out_res.wb_value, out_res.rn, out_res.wb_en, out_res.rt,
                         out_res.sx, out_res.bytes, out_res.store, out_res.ok};

  `LSWB_ASSERT_IMPL(a_fail_zero, clk, rst, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[47:1] == 47'd0, "failed decode carries nonzero fields")
  `LSWB_ASSERT_IMPL(a_ok_fields, clk, rst, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[11] && m_axis_tdata[15:12] != REG_PC, "decoded word without writeback or with pc base")
  `LSWB_ASSERT_IMPL(a_ok_size, clk, rst, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[5:2] == SIZE_BYTE || m_axis_tdata[5:2] == SIZE_HALF || m_axis_tdata[5:2] == SIZE_WORD || m_axis_tdata[5:2] == SIZE_DUAL, "bad access size")
  `LSWB_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !out_free, in_valid && $stable(in_instr) && $stable(in_thumb), "input register lost a word under stall")

endmodule

[tb/sv/tb_arm_load_store_writeback_decoder_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arm_load_store_writeback_decoder_unit
// drives trapped load/store words into the decoder and checks every result
// word against an in-bench decode model or a fixed value: a short table of
// directed words (arm word/byte and extra forms, all shift types, thumb
// wide stores and loads, rejected forms) then mostly well-formed random
// words, random idling on both streams, a long output stall and a full drain
// ----------------------------------------------------------------------------
module tb_arm_load_store_writeback_decoder_unit;
  import lswb_pkg::*;

  localparam int unsigned N_DIRECTED   = 26;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [31:0] instr;
    logic        thumb;
    logic        carry;
    logic [31:0] base;
    logic [31:0] index;
    logic [31:0] fault;
  } access_t;

  typedef struct packed {
    access_t a;
    logic    fixed;
    result_t want;
  } decode_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;

  result_t      pending_decodes [$];
  int unsigned  failures = 0;
  int unsigned  cycles = 0;
  bit           gaps_on = 1'b1;
  bit           hold_req = 1'b0;

  decode_row_t directed_rows [N_DIRECTED] = '{
    '{'{32'hE481_2004, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0}, 1'b1,
      '{1'b1, 1'b1, SIZE_WORD, 1'b0, 4'd2, 1'b1, 4'd1, 32'h0000_0003}},
    '{'{32'hE572_3FFF, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0}, 1'b0, RESULT_NONE},
    '{'{32'hE694_5F81, 1'b0, 1'b0, 32'h1000, 32'hFFFF_FFFF, 32'h0}, 1'b0, RESULT_NONE},
    '{'{32'hE694_5021, 1'b0, 1'b0, 32'h1000, 32'hFFFF_FFFF, 32'h0}, 1'b0, RESULT_NONE},
    '{'{32'hE694_5041, 1'b0, 1'b0, 32'h1000, 32'h8000_0000, 32'h0}, 1'b0, RESULT_NONE},
    '{'{32'hE694_52E1, 1'b0, 1'b0, 32'h1000, 32'h1234_5678, 32'h0}, 1'b0, RESULT_NONE},
    '{'{32'hE694_5061, 1'b0, 1'b1, 32'h1000, 32'h0000_0001, 32'h0}, 1'b0, RESULT_NONE},
    '{'{32'hE0C1_20B4, 1'b0, 1'b0, 32'h2000, 32'h0, 32'h0}, 1'b0, RESULT_NONE},
    '{'{32'hE081_20D3, 1'b0, 1'b0, 32'h2000, 32'hAAAA_5555, 32'h0}, 1'b0, RESULT_NONE},
    '{'{32'hE0D1_2FDF, 1'b0, 1'b0, 32'h2000, 32'h0, 32'h0}, 1'b0, RESULT_NONE},
    '{'{32'hE1E1_20F8, 1'b0, 1'b0, 32'hFFFF_FFFC, 32'h0, 32'h0}, 1'b0, RESULT_NONE},
    '{'{32'hE0D1_34F2, 1'b0, 1'b0, 32'h2000, 32'h0, 32'h0}, 1'b0, RESULT_NONE},
    '{'{32'hE481_F004, 1'b0, 1'b0, 32'h1000, 32'h0, 32'h0}, 1'b1, RESULT_NONE},
    '{'{32'hE48F_2004, 1'b0, 1'b0, 32'h1000, 32'h0, 32'h0}, 1'b1, RESULT_NONE},
    '{'{32'hE591_2004, 1'b0, 1'b0, 32'h1000, 32'h0, 32'h0}, 1'b1, RESULT_NONE},
    '{'{32'hEA00_0000, 1'b0, 1'b0, 32'h1000, 32'h0, 32'h0}, 1'b1, RESULT_NONE},
    '{'{32'hE081_2093, 1'b0, 1'b0, 32'h1000, 32'h0, 32'h0}, 1'b1, RESULT_NONE},
    '{'{32'h0000_E7FF, 1'b1, 1'b0, 32'h1000, 32'h0, 32'h0}, 1'b1, RESULT_NONE},
    '{'{32'hF841_2B10, 1'b1, 1'b0, 32'h0, 32'h0, 32'h8000_0000}, 1'b0, RESULT_NONE},
    '{'{32'hF911_3DFF, 1'b1, 1'b0, 32'h0, 32'h0, 32'h0}, 1'b0, RESULT_NONE},
    '{'{32'hF851_2904, 1'b1, 1'b0, 32'h0, 32'h0, 32'h0}, 1'b0, RESULT_NONE},
    '{'{32'hF85F_2D04, 1'b1, 1'b0, 32'h0, 32'h0, 32'h100}, 1'b1, RESULT_NONE},
    '{'{32'hF851_2C04, 1'b1, 1'b0, 32'h0, 32'h0, 32'h100}, 1'b1, RESULT_NONE},
    '{'{32'hF951_2D04, 1'b1, 1'b0, 32'h0, 32'h0, 32'h100}, 1'b1, RESULT_NONE},
    '{'{32'hE841_2B10, 1'b1, 1'b0, 32'h0, 32'h0, 32'h100}, 1'b1, RESULT_NONE},
    '{'{32'hF861_2B10, 1'b1, 1'b0, 32'h0, 32'h0, 32'h100}, 1'b1, RESULT_NONE}
  };

  arm_load_store_writeback_decoder_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic result_t predict_access(input access_t a);
    result_t     r;
    logic        ok;
    logic [31:0] w;
    logic [31:0] off;
    logic [4:0]  imm5;
    logic [6:0]  op2;
    logic [6:0]  ld;
    r    = RESULT_NONE;
    ok   = 1'b1;
    w    = a.instr;
    off  = '0;
    imm5 = w[11:7];
    op2  = w[26:20];
    ld   = op2 & T_LOAD_MASK;
    r.rt    = w[15:12];
    r.rn    = w[19:16];
    r.wb_en = 1'b1;
    if (!a.thumb) begin
      if ((w & ARM_CLASS_MASK) == ARM_CLASS_WB) begin
        r.store = !w[20];
        r.bytes = w[22] ? SIZE_BYTE : SIZE_WORD;
        if (!w[25]) begin
          off = {20'd0, w[11:0]};
        end else begin
          case (w[6:5])
            SH_LSL: off = a.index << imm5;
            SH_LSR: off = (imm5 == 5'd0) ? 32'd0 : a.index >> imm5;
            SH_ASR: off = (imm5 == 5'd0) ? {32{a.index[31]}} :
                          ((a.index >> imm5) |
                           (a.index[31] ? ~(32'hFFFF_FFFF >> imm5) : 32'd0));
            SH_ROR: off = (imm5 == 5'd0) ? {a.carry, a.index[31:1]} :
                          ((a.index >> imm5) | (a.index << (6'd32 - {1'b0, imm5})));
          endcase
        end
      end else if ((w & ARM_CLASS_MASK) == ARM_CLASS_EXT) begin
        case (w[7:4])
          EXT_HALF: begin
            r.store = !w[20];
            r.bytes = SIZE_HALF;
          end
          EXT_LDRD: begin
            r.store = 1'b0;
            r.bytes = w[20] ? SIZE_BYTE : SIZE_DUAL;
            r.sx    = w[20];
          end
          EXT_STRD: begin
            r.store = !w[20];
            r.bytes = w[20] ? SIZE_HALF : SIZE_DUAL;
            r.sx    = w[20];
          end
          default: ok = 1'b0;
        endcase
        off = w[22] ? {24'd0, w[11:8], w[3:0]} : a.index;
      end else begin
        ok = 1'b0;
      end
      if (r.rt == REG_PC || r.rn == REG_PC || (w[24] && !w[21])) ok = 1'b0;
      r.wb_value = w[23] ? a.base + off : a.base - off;
    end else begin
      if (w < THUMB_WIDE_MIN || w[28:27] != 2'b11) begin
        ok = 1'b0;
      end else if ((op2 & T_STORE_MASK) == 7'd0) begin
        r.store = 1'b1;
        case (w[23:21])
          3'd0:    r.bytes = SIZE_BYTE;
          3'd1:    r.bytes = SIZE_HALF;
          3'd2:    r.bytes = SIZE_WORD;
          default: ok = 1'b0;
        endcase
      end else if (ld == T_LOAD_BYTE || ld == T_LOAD_HALF || ld == T_LOAD_WORD) begin
        r.bytes = (ld == T_LOAD_BYTE) ? SIZE_BYTE :
                  (ld == T_LOAD_HALF) ? SIZE_HALF : SIZE_WORD;
        if (w[24:23] == 2'b10 && ld != T_LOAD_WORD) r.sx = 1'b1;
        else if (w[24:23] != 2'b00) ok = 1'b0;
      end else begin
        ok = 1'b0;
      end
      if (!w[11] || !w[8] || r.rn == REG_PC) ok = 1'b0;
      if (w[10]) r.wb_value = a.fault;
      else r.wb_value = w[9] ? a.fault + w[7:0] : a.fault - w[7:0];
    end
    if (!ok) r = RESULT_NONE;
    else r.ok = 1'b1;
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic access_t random_access();
    access_t     a;
    int unsigned kind;
    logic [31:0] w;
    kind    = $urandom_range(0, 99);
    w       = $urandom;
    a.thumb = 1'b0;
    a.carry = 1'($urandom_range(0, 1));
    a.base  = pick_value();
    a.index = pick_value();
    a.fault = pick_value();
    if (kind < 60) begin
      if (kind < 35) begin
        w[27:26] = 2'b01;
        case ($urandom_range(0, 3))
          0:       w[11:7] = 5'd0;
          1:       w[11:7] = 5'd31;
          default: ;
        endcase
      end else begin
        w[27:26] = 2'b00;
        case ($urandom_range(0, 2))
          0:       w[7:4] = EXT_HALF;
          1:       w[7:4] = EXT_LDRD;
          default: w[7:4] = EXT_STRD;
        endcase
      end
      if ($urandom_range(0, 9) != 0) begin
        if (w[15:12] == REG_PC) w[15:12] = 4'($urandom_range(0, 14));
        if (w[19:16] == REG_PC) w[19:16] = 4'($urandom_range(0, 14));
        w[21] = w[21] | w[24];
      end
    end else if (kind < 85) begin
      a.thumb  = 1'b1;
      w[31:27] = 5'b11111;
      if ($urandom_range(0, 1) == 1) begin
        w[26:20] = {3'b000, 3'($urandom_range(0, 3)), 1'b0};
      end else begin
        w[26:25] = 2'b00;
        case ($urandom_range(0, 3))
          0, 1:    w[24:23] = 2'b00;
          2:       w[24:23] = 2'b10;
          default: w[24:23] = 2'($urandom_range(0, 3));
        endcase
        case ($urandom_range(0, 2))
          0:       w[22:20] = T_LOAD_BYTE[2:0];
          1:       w[22:20] = T_LOAD_HALF[2:0];
          default: w[22:20] = T_LOAD_WORD[2:0];
        endcase
      end
      if ($urandom_range(0, 9) != 0) begin
        w[11] = 1'b1;
        w[8]  = 1'b1;
        if (w[19:16] == REG_PC) w[19:16] = 4'($urandom_range(0, 14));
      end
    end else if (kind < 92) begin
      a.thumb   = 1'b1;
      w[31:16] = 16'd0;
    end else begin
      a.thumb = 1'($urandom_range(0, 1));
    end
    a.instr = w;
    return a;
  endfunction

  task automatic send_access(input access_t a, input logic fixed, input result_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, a.fault, a.index, a.base, a.carry, a.instr};
    s_axis_tuser  <= a.thumb;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_decodes.push_back(fixed ? want : predict_access(a));
  endtask

  task automatic drain_decodes();
    s_axis_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  // output side idling
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!gaps_on) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                                                   $urandom_range(0, 2);
      end
    end
  end

  always @(posedge clk) begin : check_result
    result_t want;
    result_t got;
    got.ok       = m_axis_tdata[0];
    got.store    = m_axis_tdata[1];
    got.bytes    = m_axis_tdata[5:2];
    got.sx       = m_axis_tdata[6];
    got.rt       = m_axis_tdata[10:7];
    got.wb_en    = m_axis_tdata[11];
    got.rn       = m_axis_tdata[15:12];
    got.wb_value = m_axis_tdata[47:16];
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_decodes.size() == 0) begin
        $error("result word with no decode pending");
        failures++;
      end else begin
        want = pending_decodes.pop_front();
        if (got.ok !== want.ok) begin
          $error("decoded_ok: expected %0d, got %0d", want.ok, got.ok);
          failures++;
        end
        if (got.store !== want.store) begin
          $error("is_store: expected %0d, got %0d", want.store, got.store);
          failures++;
        end
        if (got.bytes !== want.bytes) begin
          $error("access_bytes: expected %0d, got %0d", want.bytes, got.bytes);
          failures++;
        end
        if (got.sx !== want.sx) begin
          $error("sign_ext: expected %0d, got %0d", want.sx, got.sx);
          failures++;
        end
        if (got.rt !== want.rt) begin
          $error("target_reg: expected %0d, got %0d", want.rt, got.rt);
          failures++;
        end
        if (got.wb_en !== want.wb_en) begin
          $error("writeback_enable: expected %0d, got %0d", want.wb_en, got.wb_en);
          failures++;
        end
        if (got.rn !== want.rn) begin
          $error("writeback_reg: expected %0d, got %0d", want.rn, got.rn);
          failures++;
        end
        if (got.wb_value !== want.wb_value) begin
          $error("writeback_value: expected %h, got %h", want.wb_value, got.wb_value);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned i;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (i = 0; i < N_DIRECTED; i++) begin
      send_access(directed_rows[i].a, directed_rows[i].fixed, directed_rows[i].want);
    end
    drain_decodes();
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // no idling stretch, then a long output hold while input keeps coming
      if (i == 300) gaps_on = 1'b0;
      if (i == 400) hold_req = 1'b1;
      if (i == 500) gaps_on = 1'b1;
      if (i == 650) drain_decodes();
      send_access(random_access(), 1'b0, RESULT_NONE);
    end
    drain_decodes();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
